// ===== hdl/gdad_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gdad_pkg
// Types, constants and helpers shared by the date adder's controller and
// datapath.
// ---------------------------------------------------------------------------
package gdad_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int OFS_W   = 16;
   // running day count: 16383 years of days plus a full offset fits in 23 bits
   localparam int N_W     = 23;
   // walking year counter, wide enough for any MAX_YEAR up to 65535
   localparam int Y_W     = 16;
   localparam int YLEN_W  = 9;
   localparam int C100_W  = 7;
   localparam int C400_W  = 9;

   localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
   localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

   localparam logic [YLEN_W-1:0] COMMON_YEAR_DAYS = 9'd365;
   localparam logic [YLEN_W-1:0] LEAP_YEAR_DAYS   = 9'd366;
   localparam logic [DAY_W-1:0]  LEAP_FEB_DAYS    = 5'd29;
   localparam logic [C100_W-1:0] CENTURY_LAST     = 7'd99;
   localparam logic [C400_W-1:0] QUAD_CENT_LAST   = 9'd399;

   localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_ACC_YEAR,
      OP_ACC_MONTH,
      OP_ADD_OFS,
      OP_DEC_YEAR,
      OP_DEC_MONTH,
      OP_SET_OVF
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC_YEAR,
      ST_ACC_MONTH,
      ST_DEC_YEAR,
      ST_DEC_MONTH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type op;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic year_lt;      // walk year still below the start year
      logic month_lt;     // walk month still below the start month
      logic n_gt_ylen;    // day count spills past the current year
      logic y_at_max;     // one more year would pass MAX_YEAR
      logic month_more;   // day count spills past the current month, before December
   } status_type;

   function automatic logic leap_of(input logic [1:0] c4,
                                    input logic [C100_W-1:0] c100,
                                    input logic [C400_W-1:0] c400);
      return ((c4 == 2'd0) && (c100 != '0)) || (c400 == '0);
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [MONTH_W-1:0] idx;
      idx = m - JANUARY;
      if ((m == FEBRUARY) && leap)
         return LEAP_FEB_DAYS;
      return MONTH_LEN[idx];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/gdad_dpath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gdad_dpath
// Day-count datapath: one shared add/subtract unit that walks years and
// months, with mod 4/100/400 counters for the leap rule and the result
// register.
// ---------------------------------------------------------------------------
module gdad_dpath #(
   parameter int MAX_YEAR = 9999
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire gdad_pkg::cmd_type      cmd,
   output gdad_pkg::status_type        status,
   input  wire [gdad_pkg::DAY_W-1:0]   req_start_day,
   input  wire [gdad_pkg::MONTH_W-1:0] req_start_month,
   input  wire [gdad_pkg::YEAR_W-1:0]  req_start_year,
   input  wire [gdad_pkg::OFS_W-1:0]   req_day_offset,
   output logic [gdad_pkg::DAY_W-1:0]   rsp_result_day,
   output logic [gdad_pkg::MONTH_W-1:0] rsp_result_month,
   output logic [gdad_pkg::YEAR_W-1:0]  rsp_result_year,
   output logic                         rsp_year_overflow
);
   import gdad_pkg::*;

   localparam logic [Y_W-1:0] MAX_Y = Y_W'(MAX_YEAR);

   // request payload
   logic [DAY_W-1:0]   day_ff, day_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [OFS_W-1:0]   offset_ff, offset_in;

   // walk state
   logic [N_W-1:0]     n_ff, n_in;
   logic [Y_W-1:0]     y_ff, y_in;
   logic [MONTH_W-1:0] m_ff, m_in;
   logic [1:0]         c4_ff, c4_in;
   logic [C100_W-1:0]  c100_ff, c100_in;
   logic [C400_W-1:0]  c400_ff, c400_in;
   logic               ovf_ff, ovf_in;

   // result register
   logic [DAY_W-1:0]   res_day_ff, res_day_in;
   logic [MONTH_W-1:0] res_month_ff, res_month_in;
   logic [YEAR_W-1:0]  res_year_ff, res_year_in;
   logic               res_ovf_ff, res_ovf_in;

   logic               leap;
   logic               year_zero;
   logic [YLEN_W-1:0]  ylen;
   logic [DAY_W-1:0]   dim_acc;
   logic [DAY_W-1:0]   dim_dec;
   logic [N_W-1:0]     ylen_ext;

   assign leap      = leap_of(c4_ff, c100_ff, c400_ff);
   // year zero counts as leap when its months are summed
   assign year_zero = (year_ff == '0);
   assign ylen      = leap ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS;
   assign ylen_ext  = N_W'(ylen);
   assign dim_acc   = month_days(m_ff, leap || year_zero);
   assign dim_dec   = month_days(m_ff, leap);

   always_comb begin
      status.year_lt    = (y_ff < Y_W'(year_ff));
      status.month_lt   = (m_ff < month_ff);
      status.n_gt_ylen  = (n_ff > ylen_ext);
      status.y_at_max   = (y_ff >= MAX_Y);
      status.month_more = (m_ff != DECEMBER) && (n_ff > N_W'(dim_dec));
   end

   always_comb begin
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      offset_in = offset_ff;
      n_in      = n_ff;
      y_in      = y_ff;
      m_in      = m_ff;
      c4_in     = c4_ff;
      c100_in   = c100_ff;
      c400_in   = c400_ff;
      ovf_in    = ovf_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            day_in    = req_start_day;
            year_in   = req_start_year;
            offset_in = req_day_offset;
            if (req_start_month < JANUARY)
               month_in = JANUARY;
            else if (req_start_month > DECEMBER)
               month_in = DECEMBER;
            else
               month_in = req_start_month;
            n_in    = '0;
            y_in    = Y_W'(1);
            m_in    = JANUARY;
            c4_in   = 2'd1;
            c100_in = C100_W'(1);
            c400_in = C400_W'(1);
            ovf_in  = 1'b0;
         end
         OP_ACC_YEAR, OP_DEC_YEAR: begin
            n_in    = (cmd.op == OP_ACC_YEAR) ? n_ff + ylen_ext : n_ff - ylen_ext;
            y_in    = y_ff + Y_W'(1);
            c4_in   = c4_ff + 2'd1;
            c100_in = (c100_ff == CENTURY_LAST) ? '0 : c100_ff + C100_W'(1);
            c400_in = (c400_ff == QUAD_CENT_LAST) ? '0 : c400_ff + C400_W'(1);
         end
         OP_ACC_MONTH: begin
            n_in = n_ff + N_W'(dim_acc);
            m_in = m_ff + 4'd1;
         end
         OP_ADD_OFS: begin
            n_in    = n_ff + N_W'(day_ff) + N_W'(offset_ff);
            y_in    = Y_W'(1);
            m_in    = JANUARY;
            c4_in   = 2'd1;
            c100_in = C100_W'(1);
            c400_in = C400_W'(1);
         end
         OP_DEC_MONTH: begin
            n_in = n_ff - N_W'(dim_dec);
            m_in = m_ff + 4'd1;
         end
         OP_SET_OVF: begin
            ovf_in = 1'b1;
         end
         OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      res_day_in   = res_day_ff;
      res_month_in = res_month_ff;
      res_year_in  = res_year_ff;
      res_ovf_in   = res_ovf_ff;
      if (cmd.out_load) begin
         res_ovf_in   = ovf_ff;
         res_day_in   = ovf_ff ? '0 : n_ff[DAY_W-1:0];
         res_month_in = ovf_ff ? '0 : m_ff;
         res_year_in  = ovf_ff ? '0 : y_ff[YEAR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_ff    <= Y_W'(1);
         m_ff    <= JANUARY;
         c4_ff   <= 2'd1;
         c100_ff <= C100_W'(1);
         c400_ff <= C400_W'(1);
      end else begin
         y_ff    <= y_in;
         m_ff    <= m_in;
         c4_ff   <= c4_in;
         c100_ff <= c100_in;
         c400_ff <= c400_in;
      end
   end

   always_ff @(posedge clock) begin
      day_ff       <= day_in;
      month_ff     <= month_in;
      year_ff      <= year_in;
      offset_ff    <= offset_in;
      n_ff         <= n_in;
      ovf_ff       <= ovf_in;
      res_day_ff   <= res_day_in;
      res_month_ff <= res_month_in;
      res_year_ff  <= res_year_in;
      res_ovf_ff   <= res_ovf_in;
   end

   assign rsp_result_day    = res_day_ff;
   assign rsp_result_month  = res_month_ff;
   assign rsp_result_year   = res_year_ff;
   assign rsp_year_overflow = res_ovf_ff;

   // mod 4 counter tracks the low bits of the walking year
   a_c4_tracks_year: assert property (@(posedge clock) disable iff (reset)
      c4_ff == y_ff[1:0])
      else $error("mod 4 counter out of step with year");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (m_ff >= JANUARY) && (m_ff <= DECEMBER))
      else $error("walk month out of range");

   a_ovf_zero_date: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> !rsp_year_overflow ||
         ((rsp_result_day == '0) && (rsp_result_month == '0) && (rsp_result_year == '0)))
      else $error("overflow result carries a nonzero date");

endmodule
`default_nettype wire

// ===== hdl/gdad_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gdad_ctrl
// Sequencer for the date adder: steps the datapath through the year and
// month walks and owns the request/response handshakes.
// ---------------------------------------------------------------------------
module gdad_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   input  wire gdad_pkg::status_type status,
   output gdad_pkg::cmd_type         cmd
);
   import gdad_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_ACC_YEAR;
         ST_ACC_YEAR:  if (!status.year_lt) state_in = ST_ACC_MONTH;
         ST_ACC_MONTH: if (!status.month_lt) state_in = ST_DEC_YEAR;
         ST_DEC_YEAR: begin
            if (!status.n_gt_ylen)
               state_in = ST_DEC_MONTH;
            else if (status.y_at_max)
               state_in = ST_FINISH;
         end
         ST_DEC_MONTH: if (!status.month_more) state_in = ST_FINISH;
         ST_FINISH:    if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = OP_NONE;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) cmd.op = OP_LOAD;
         ST_ACC_YEAR:  if (status.year_lt) cmd.op = OP_ACC_YEAR;
         ST_ACC_MONTH: cmd.op = status.month_lt ? OP_ACC_MONTH : OP_ADD_OFS;
         ST_DEC_YEAR: begin
            if (status.n_gt_ylen)
               cmd.op = status.y_at_max ? OP_SET_OVF : OP_DEC_YEAR;
         end
         ST_DEC_MONTH: if (status.month_more) cmd.op = OP_DEC_MONTH;
         ST_FINISH:    cmd.out_load = out_free;
         default:      cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      if (cmd.out_load)
         rsp_valid_in = 1'b1;
      else
         rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   a_accept_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_ACC_YEAR))
      else $error("accepted request did not start the year walk");

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("finished request not presented");

endmodule
`default_nettype wire

// ===== hdl/gregorian_date_add_days.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day offset to a proleptic Gregorian date through a day count.
// ---------------------------------------------------------------------------
// One request at a time. From the edge that takes a request, the walk adds up
// the years before the start year and the months before the start month, adds
// the start day and the offset, then subtracts year and month lengths until
// only the day is left. The result is presented once a stalled previous
// result has left the output register. A start year of 0 adds no earlier
// years and sums its months as a leap year, and the start month counts after
// clamping to 1..12. The date is converted to a day count and back by a
// single add/subtract unit that walks one year or one month per cycle. In
// the cycle after the result is loaded the block is idle again and takes a
// new request even while that result is stalled. A result year above MAX_YEAR
// gives rsp_year_overflow with zero date fields, and the walk stops there.
module gregorian_date_add_days #(
   parameter int MAX_YEAR = 9999
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire [gdad_pkg::DAY_W-1:0]   req_start_day,
   input  wire [gdad_pkg::MONTH_W-1:0] req_start_month,
   input  wire [gdad_pkg::YEAR_W-1:0]  req_start_year,
   input  wire [gdad_pkg::OFS_W-1:0]   req_day_offset,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [gdad_pkg::DAY_W-1:0]   rsp_result_day,
   output logic [gdad_pkg::MONTH_W-1:0] rsp_result_month,
   output logic [gdad_pkg::YEAR_W-1:0]  rsp_result_year,
   output logic                         rsp_year_overflow
);
   import gdad_pkg::*;

   cmd_type    cmd;
   status_type status;

   gdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gdad_dpath #(
      .MAX_YEAR (MAX_YEAR)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_start_day     (req_start_day),
      .req_start_month   (req_start_month),
      .req_start_year    (req_start_year),
      .req_day_offset    (req_day_offset),
      .rsp_result_day    (rsp_result_day),
      .rsp_result_month  (rsp_result_month),
      .rsp_result_year   (rsp_result_year),
      .rsp_year_overflow (rsp_year_overflow)
   );

endmodule
`default_nettype wire

// ===== bench/gregorian_date_add_days_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gregorian_date_add_days_tb
// Drives dates and day offsets into the date adder under random idling on both
// channels; checks typed rows as given, others by an in-bench calendar model.
// ---------------------------------------------------------------------------
module gregorian_date_add_days_tb;

   import gdad_pkg::*;

   localparam int YEAR_LIMIT   = 9999;
   localparam int RANDOM_ITEMS = 74;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 10_000_000;

   localparam bit TYPED   = 1'b1;
   localparam bit PREDICT = 1'b0;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic               overflow;
   } date_result_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [OFS_W-1:0]   ofs;
      logic               typed;
      date_result_type    want;
   } date_case_type;

   localparam date_result_type YEAR_OVERFLOWED = '{0, 0, 0, 1};

   localparam int NUM_DIRECTED = 26;
   localparam date_case_type DIRECTED_CASES [NUM_DIRECTED] = '{
      '{1,  1,  1,     0,     TYPED,   '{1,  1,  1,    0}},
      '{31, 12, 9999,  0,     TYPED,   '{31, 12, 9999, 0}},
      '{31, 12, 9999,  1,     TYPED,   YEAR_OVERFLOWED},
      // day count of zero stays in January of year 1
      '{0,  1,  1,     0,     TYPED,   '{0,  1,  1,    0}},
      '{0,  1,  0,     0,     TYPED,   '{0,  1,  1,    0}},
      '{0,  0,  0,     0,     TYPED,   '{0,  1,  1,    0}},
      '{31, 15, 16383, 65535, TYPED,   YEAR_OVERFLOWED},
      '{28, 2,  2000,  1,     TYPED,   '{29, 2,  2000, 0}},
      '{28, 2,  1900,  1,     TYPED,   '{1,  3,  1900, 0}},
      '{28, 2,  2001,  1,     TYPED,   '{1,  3,  2001, 0}},
      // day past the end of February spills into March
      '{31, 2,  2023,  0,     TYPED,   '{3,  3,  2023, 0}},
      '{31, 2,  2024,  0,     TYPED,   '{2,  3,  2024, 0}},
      '{31, 12, 1999,  1,     TYPED,   '{1,  1,  2000, 0}},
      // month above 12 counts as December, month 0 as January
      '{15, 13, 100,   10,    TYPED,   '{25, 12, 100,  0}},
      '{1,  0,  5,     0,     TYPED,   '{1,  1,  5,    0}},
      '{0,  6,  7,     0,     TYPED,   '{31, 5,  7,    0}},
      '{29, 2,  2100,  0,     TYPED,   '{1,  3,  2100, 0}},
      '{1,  1,  10000, 0,     TYPED,   YEAR_OVERFLOWED},
      '{31, 12, 400,   0,     TYPED,   '{31, 12, 400,  0}},
      // year zero has no earlier years
      '{31, 12, 0,     0,     PREDICT, '0},
      '{1,  3,  0,     0,     PREDICT, '0},
      '{1,  1,  1,     65535, PREDICT, '0},
      '{31, 12, 9820,  65535, PREDICT, '0},
      '{16, 7,  2500,  32768, PREDICT, '0},
      '{5,  8,  1,     21845, PREDICT, '0},
      '{10, 10, 8191,  43690, PREDICT, '0}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [DAY_W-1:0]     req_start_day;
   logic [MONTH_W-1:0]   req_start_month;
   logic [YEAR_W-1:0]    req_start_year;
   logic [OFS_W-1:0]     req_day_offset;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DAY_W-1:0]     rsp_result_day;
   logic [MONTH_W-1:0]   rsp_result_month;
   logic [YEAR_W-1:0]    rsp_result_year;
   logic                 rsp_year_overflow;

   date_result_type pending_dates [$];
   int           fail_count    = 0;
   int           cycle_count   = 0;
   int           req_gap_pct   = 7;
   int           rsp_stall_pct = 78;

   gregorian_date_add_days #(
      .MAX_YEAR(YEAR_LIMIT)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_day     (req_start_day),
      .req_start_month   (req_start_month),
      .req_start_year    (req_start_year),
      .req_day_offset    (req_day_offset),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_day    (rsp_result_day),
      .rsp_result_month  (rsp_result_month),
      .rsp_result_year   (rsp_result_year),
      .rsp_year_overflow (rsp_year_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit is_leap_year(int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function automatic int unsigned month_length(int unsigned yr, int unsigned mo);
      case (mo)
         2: return is_leap_year(yr) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   // Date to day count (1 Jan of year 1 is day 1), add the offset, walk back.
   function automatic date_result_type advance_date(int unsigned dy, int unsigned mo,
                                                   int unsigned yr, int unsigned ofs);
      int unsigned     cnt;
      int unsigned     prior;
      int unsigned     walk_yr;
      int unsigned     walk_mo;
      int unsigned     ylen;
      date_result_type res;
      if (mo < 1) mo = 1;
      if (mo > 12) mo = 12;
      cnt = 0;
      if (yr > 0) begin
         prior = yr - 1;
         cnt = 365 * prior + prior / 4 - prior / 100 + prior / 400;
      end
      for (int m = 1; m < mo; m++)
         cnt += month_length(yr, m);
      cnt += dy + ofs;
      walk_yr = 1;
      ylen = 365;
      while (cnt > ylen) begin
         cnt -= ylen;
         walk_yr++;
         ylen = is_leap_year(walk_yr) ? 366 : 365;
      end
      walk_mo = 1;
      while (walk_mo < 12 && cnt > month_length(walk_yr, walk_mo)) begin
         cnt -= month_length(walk_yr, walk_mo);
         walk_mo++;
      end
      if (walk_yr > YEAR_LIMIT) begin
         res = YEAR_OVERFLOWED;
      end else begin
         res.day      = DAY_W'(cnt);
         res.month    = MONTH_W'(walk_mo);
         res.year     = YEAR_W'(walk_yr);
         res.overflow = 1'b0;
      end
      return res;
   endfunction

   task automatic send_request(int unsigned dy, int unsigned mo, int unsigned yr,
                               int unsigned ofs, bit typed, date_result_type typed_want);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_start_day   <= DAY_W'(dy);
      req_start_month <= MONTH_W'(mo);
      req_start_year  <= YEAR_W'(yr);
      req_day_offset  <= OFS_W'(ofs);
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      // request taken at this edge
      pending_dates.push_back(typed ? typed_want : advance_date(dy, mo, yr, ofs));
   endtask

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);

   always @(posedge clock) begin
      date_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_dates.size() == 0) begin
            $error("unexpected result: day %0d month %0d year %0d overflow %0b",
                   rsp_result_day, rsp_result_month, rsp_result_year, rsp_year_overflow);
            fail_count++;
         end else begin
            want = pending_dates.pop_front();
            compare_field("result_day", want.day, rsp_result_day);
            compare_field("result_month", want.month, rsp_result_month);
            compare_field("result_year", want.year, rsp_result_year);
            compare_field("year_overflow", want.overflow, rsp_year_overflow);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_dates.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int unsigned   dy;
      int unsigned   mo;
      int unsigned   yr;
      int unsigned   ofs;
      date_case_type row;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_start_day   <= '0;
      req_start_month <= '0;
      req_start_year  <= '0;
      req_day_offset  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_CASES[i]) begin
         row = DIRECTED_CASES[i];
         send_request(row.day, row.month, row.year, row.ofs, row.typed, row.want);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            req_gap_pct   = 78;
            rsp_stall_pct = 7;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end
         // the walk is linear in the year, so only every tenth date is far out
         if (i % 10 == 0) begin
            yr = $urandom_range(0, 16383);
            mo = $urandom_range(0, 15);
            dy = $urandom_range(0, 31);
         end else if ($urandom_range(0, 7) == 0) begin
            yr = $urandom_range(0, 300);
            mo = $urandom_range(0, 15);
            dy = $urandom_range(0, 31);
         end else begin
            yr = $urandom_range(1, 300);
            mo = $urandom_range(1, 12);
            dy = $urandom_range(1, month_length(yr, mo));
         end
         ofs = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 999);
         send_request(dy, mo, yr, ofs, PREDICT, '0);
      end
      req_valid <= 1'b0;

      while (pending_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
